[hw/rtl/mte_pkg.sv]
package mte_pkg;

  localparam int MaxSteps = 63;
  localparam int MaxNotes = 4;

  localparam logic [2:0] CMD_NOTE  = 3'd0;
  localparam logic [2:0] CMD_PROG  = 3'd1;
  localparam logic [2:0] CMD_CTRL  = 3'd2;
  localparam logic [2:0] CMD_PITCH = 3'd3;
  localparam logic [2:0] CMD_CRAMP = 3'd4;
  localparam logic [2:0] CMD_PRAMP = 3'd5;
  localparam logic [2:0] CMD_END   = 3'd6;

  localparam logic [7:0] ST_NOTE_ON = 8'h90;
  localparam logic [7:0] ST_CTRL    = 8'hB0;
  localparam logic [7:0] ST_PROG    = 8'hC0;
  localparam logic [7:0] ST_PITCH   = 8'hE0;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] META_EOT   = 8'h2F;
  localparam logic [7:0] VLQ_CONT   = 8'b1000_0000;

  localparam int DivW    = 28;
  localparam int DivCntW = 5;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  channel;
    logic [27:0] delta;
    logic [27:0] hold;
    logic [6:0]  number;
    logic [13:0] first;
    logic [13:0] endv;
    logic [5:0]  steps;
    logic [2:0]  count;
    logic [27:0] notes;
    logic [6:0]  total;
  } cmd_t;

  typedef struct packed {
    logic [31:0] delta_bytes;
    logic [2:0]  delta_length;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [1:0]  data_count;
    logic [31:0] track_length;
    logic        last;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } vlq_t;

  function automatic vlq_t vlq_encode(input logic [27:0] d);
    vlq_t r;
    r.bytes = '0;
    if (d[27:21] != 7'd0) begin
      r.bytes = {VLQ_CONT | {1'b0, d[27:21]}, VLQ_CONT | {1'b0, d[20:14]},
                 VLQ_CONT | {1'b0, d[13:7]}, {1'b0, d[6:0]}};
      r.len = 3'd4;
    end else if (d[20:14] != 7'd0) begin
      r.bytes = {8'd0, VLQ_CONT | {1'b0, d[20:14]},
                 VLQ_CONT | {1'b0, d[13:7]}, {1'b0, d[6:0]}};
      r.len = 3'd3;
    end else if (d[13:7] != 7'd0) begin
      r.bytes = {16'd0, VLQ_CONT | {1'b0, d[13:7]}, {1'b0, d[6:0]}};
      r.len = 3'd2;
    end else begin
      r.bytes = {24'd0, 1'b0, d[6:0]};
      r.len = 3'd1;
    end
    return r;
  endfunction

endpackage

[hw/rtl/mte_front.sv]
module mte_front import mte_pkg::*; (
  input  logic        in_valid,
  input  logic        full,
  input  logic [2:0]  command,
  input  logic [3:0]  channel,
  input  logic [27:0] delta_ticks,
  input  logic [27:0] hold_ticks,
  input  logic [6:0]  number,
  input  logic [13:0] first_value,
  input  logic [13:0] end_value,
  input  logic [5:0]  ramp_steps,
  input  logic [2:0]  note_count,
  input  logic [27:0] notes,
  output logic        push,
  output cmd_t        cmd
);

  logic [2:0] cnt;
  logic [5:0] stp;

  // Unknown commands are accepted and dropped here.
  assign push = in_valid && !full && (command != 3'd7);

  always_comb begin
    cnt = note_count;
    if (note_count == 3'd0) cnt = 3'd1;
    if (note_count > 3'(MaxNotes)) cnt = 3'(MaxNotes);
    stp = ramp_steps;
    if (ramp_steps > 6'(MaxSteps)) stp = 6'(MaxSteps);
    cmd.command = command;
    cmd.channel = channel;
    cmd.delta   = delta_ticks;
    cmd.hold    = hold_ticks;
    cmd.number  = number;
    cmd.first   = first_value;
    cmd.endv    = end_value;
    cmd.steps   = stp;
    cmd.count   = cnt;
    cmd.notes   = notes;
    unique case (command) inside
      CMD_NOTE:             cmd.total = {3'd0, cnt, 1'b0};
      CMD_CRAMP, CMD_PRAMP: cmd.total = {1'b0, stp} + 7'd1;
      default:              cmd.total = 7'd1;
    endcase
  end

endmodule

[hw/rtl/mte_fifo.sv]
module mte_fifo import mte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_t       wdata,
  input  logic       pop,
  output cmd_t       rdata,
  output fifo_stat_t stat
);

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] level;

  assign rdata      = mem[rptr];
  assign stat.full  = (level == 2'd2);
  assign stat.empty = (level == 2'd0);

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      level <= level + 2'(push) - 2'(pop);
    end
  end

endmodule

[hw/rtl/mte_div.sv]
module mte_div import mte_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DivW-1:0] dividend,
  input  logic [5:0]      divisor,
  output logic            busy,
  output logic [DivW-1:0] quotient,
  output logic [5:0]      remainder
);

  logic [DivCntW-1:0] cnt;
  logic [6:0]         rem_sh;
  logic               ge;
  logic [5:0]         dsr;

  assign rem_sh = {remainder, quotient[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  // Restoring division, one quotient bit per cycle. The divisor is held for
  // the whole run because the queue head moves on once the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DivCntW'(DivW - 1);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      cnt <= cnt - DivCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DivW-2:0], ge};
      remainder <= ge ? 6'(rem_sh - {1'b0, dsr}) : rem_sh[5:0];
    end
  end

endmodule

[hw/rtl/mte_back.sv]
module mte_back import mte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fifo_stat_t fstat,
  input  cmd_t       head,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output event_t     ev_out
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  logic [1:0]  state;
  cmd_t        cur;
  logic [6:0]  ev;
  logic [13:0] vq;
  logic [5:0]  tr;
  logic [5:0]  vr;
  logic        neg;
  logic [31:0] tcount;

  logic            div_start;
  logic            tbusy;
  logic            vbusy;
  logic [DivW-1:0] tq_h;
  logic [DivW-1:0] vq_h;
  logic [5:0]      tr_h;
  logic [5:0]      vr_h;
  logic [13:0]     head_diff;
  logic            is_ramp_head;

  logic        emit;
  logic        is_ramp;
  logic [6:0]  t_sum;
  logic [6:0]  v_sum;
  logic        t_c;
  logic        v_c;
  logic [5:0]  tr_next;
  logic [5:0]  vr_next;
  logic [13:0] vq_next;
  logic [13:0] val;
  logic [27:0] dl;
  logic [7:0]  st;
  logic [7:0]  d1;
  logic [7:0]  d2;
  logic [1:0]  dc;
  logic [1:0]  nidx;
  logic        noff;
  logic [6:0]  nsel;
  vlq_t        vlq;
  logic [31:0] tcount_next;

  assign is_ramp_head = (head.command == CMD_CRAMP) || (head.command == CMD_PRAMP);
  assign pop          = (state == S_IDLE) && !fstat.empty;
  assign div_start    = pop && is_ramp_head && (head.steps != 6'd0);
  assign head_diff    = (head.endv < head.first) ? head.first - head.endv
                                                 : head.endv - head.first;

  mte_div u_tdiv (
    .clk(clk), .rst(rst), .start(div_start), .dividend(head.hold),
    .divisor(head.steps), .busy(tbusy), .quotient(tq_h), .remainder(tr_h));

  mte_div u_vdiv (
    .clk(clk), .rst(rst), .start(div_start), .dividend({14'd0, head_diff}),
    .divisor(head.steps), .busy(vbusy), .quotient(vq_h), .remainder(vr_h));

  assign emit    = (state == S_RUN) && (!out_valid || !out_stall);
  assign is_ramp = (cur.command == CMD_CRAMP) || (cur.command == CMD_PRAMP);

  // Step k adds hold/S and diff/S with carries out of the remainders.
  always_comb begin
    t_sum   = {1'b0, tr} + {1'b0, tr_h};
    v_sum   = {1'b0, vr} + {1'b0, vr_h};
    t_c     = t_sum >= {1'b0, cur.steps};
    v_c     = v_sum >= {1'b0, cur.steps};
    tr_next = t_c ? 6'(t_sum - {1'b0, cur.steps}) : t_sum[5:0];
    vr_next = v_c ? 6'(v_sum - {1'b0, cur.steps}) : v_sum[5:0];
    vq_next = vq + vq_h[13:0] + 14'(v_c);
    val     = (ev == 7'd0) ? cur.first
            : (neg ? cur.first - vq_next : cur.first + vq_next);
  end

  always_comb begin
    noff = ev >= {4'd0, cur.count};
    nidx = noff ? 2'(ev - {4'd0, cur.count}) : ev[1:0];
    case (nidx)
      2'd0:    nsel = cur.notes[6:0];
      2'd1:    nsel = cur.notes[13:7];
      2'd2:    nsel = cur.notes[20:14];
      default: nsel = cur.notes[27:21];
    endcase
    dl = (ev == 7'd0) ? cur.delta : 28'd0;
    st = ST_NOTE_ON | {4'd0, cur.channel};
    d1 = {1'b0, cur.number};
    d2 = {cur.first[7:0]};
    dc = 2'd2;
    unique case (cur.command)
      CMD_NOTE: begin
        if (ev == {4'd0, cur.count}) dl = cur.hold;
        d1 = {1'b0, nsel};
        d2 = noff ? 8'd0 : cur.first[7:0];
      end
      CMD_PROG: begin
        st = ST_PROG | {4'd0, cur.channel};
        d2 = 8'd0;
        dc = 2'd1;
      end
      CMD_CTRL: st = ST_CTRL | {4'd0, cur.channel};
      CMD_PITCH: begin
        st = ST_PITCH | {4'd0, cur.channel};
        d1 = {1'b0, cur.first[6:0]};
        d2 = {1'b0, cur.first[13:7]};
      end
      CMD_CRAMP: begin
        if (ev != 7'd0) dl = tq_h + 28'(t_c);
        st = ST_CTRL | {4'd0, cur.channel};
        d2 = val[7:0];
      end
      CMD_PRAMP: begin
        if (ev != 7'd0) dl = tq_h + 28'(t_c);
        st = ST_PITCH | {4'd0, cur.channel};
        d1 = {1'b0, val[6:0]};
        d2 = {1'b0, val[13:7]};
      end
      default: begin
        // End of track always goes out with a zero delta.
        dl = 28'd0;
        st = ST_META;
        d1 = META_EOT;
        d2 = 8'd0;
      end
    endcase
    vlq         = vlq_encode(dl);
    tcount_next = tcount + 32'(vlq.len) + 32'd1 + 32'(dc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      tcount    <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) state <= div_start ? S_DIV : S_RUN;
        end
        S_DIV: begin
          if (!tbusy && !vbusy) state <= S_RUN;
        end
        S_RUN: begin
          if (emit) begin
            tcount <= (cur.command == CMD_END) ? 32'd0 : tcount_next;
            if (ev == cur.total - 7'd1) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      ev  <= '0;
      vq  <= '0;
      tr  <= '0;
      vr  <= '0;
      neg <= head.endv < head.first;
    end else if (emit) begin
      ev <= ev + 7'd1;
      if (is_ramp && ev != 7'd0) begin
        vq <= vq_next;
        tr <= tr_next;
        vr <= vr_next;
      end
    end
    if (emit) begin
      ev_out.delta_bytes  <= vlq.bytes;
      ev_out.delta_length <= vlq.len;
      ev_out.status_byte  <= st;
      ev_out.data_one     <= d1;
      ev_out.data_two     <= d2;
      ev_out.data_count   <= dc;
      ev_out.track_length <= tcount_next;
      ev_out.last         <= (ev == cur.total - 7'd1);
    end
  end

endmodule

[hw/rtl/midi_track_event_encoder_top.sv]
// Order: the first event of a plain request is registered in the request queue, then in
// the sequencer's request register and then in the output register. Ramps with a nonzero
// step count first pass through the two serial step dividers.
// Throughput: one event per cycle within a request while the output is not stalled; a
// request makes up to 64 events, and the sequencer goes back to idle between requests.
// Reset (rst, synchronous) empties the request queue, idles the sequencer, drops any
// pending output event and clears the running track byte count.
module midi_track_event_encoder_top import mte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [3:0]  channel,
  input  logic [27:0] delta_ticks,
  input  logic [27:0] hold_ticks,
  input  logic [6:0]  number,
  input  logic [13:0] first_value,
  input  logic [13:0] end_value,
  input  logic [5:0]  ramp_steps,
  input  logic [2:0]  note_count,
  input  logic [27:0] notes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] delta_bytes,
  output logic [2:0]  delta_length,
  output logic [7:0]  status_byte,
  output logic [7:0]  data_one,
  output logic [7:0]  data_two,
  output logic [1:0]  data_count,
  output logic [31:0] track_length,
  output logic        last
);

  // The front end clamps counts, works out how many events a request makes
  // and drops unknown commands before they reach the queue.
  logic       push;
  logic       pop;
  cmd_t       front_cmd;
  cmd_t       head;
  fifo_stat_t fstat;
  event_t     ev;

  // The input stalls only when the two-entry request queue is full.
  assign in_stall = fstat.full;

  mte_front u_front (
    .in_valid(in_valid), .full(fstat.full), .command(command), .channel(channel),
    .delta_ticks(delta_ticks), .hold_ticks(hold_ticks), .number(number),
    .first_value(first_value), .end_value(end_value), .ramp_steps(ramp_steps),
    .note_count(note_count), .notes(notes), .push(push), .cmd(front_cmd));

  mte_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(front_cmd), .pop(pop),
    .rdata(head), .stat(fstat));

  // The back end walks the events of one request and keeps the byte count.
  mte_back u_back (
    .clk(clk), .rst(rst), .fstat(fstat), .head(head), .pop(pop),
    .out_stall(out_stall), .out_valid(out_valid), .ev_out(ev));

  assign delta_bytes  = ev.delta_bytes;
  assign delta_length = ev.delta_length;
  assign status_byte  = ev.status_byte;
  assign data_one     = ev.data_one;
  assign data_two     = ev.data_two;
  assign data_count   = ev.data_count;
  assign track_length = ev.track_length;
  assign last         = ev.last;

  a_fifo_stat: assert property (@(posedge clk) disable iff (rst)
    !(fstat.full && fstat.empty))
    else $error("queue reports full and empty at once");

  a_eot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_byte == ST_META |-> last && delta_bytes == 32'd0)
    else $error("end of track event malformed");

  a_prog_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((data_count == 2'd1) == (status_byte[7:4] == ST_PROG[7:4])))
    else $error("data count does not match status");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> delta_length != 3'd0 && delta_length <= 3'd4)
    else $error("delta length out of range");

endmodule

[tb/midi_track_event_checker.sv]
// Watches both channels of the encoder, predicts the track events of every
// accepted request and compares each emitted event against the oldest one
// still expected.
module midi_track_event_checker import mte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  command,
  input  logic [3:0]  channel,
  input  logic [27:0] delta_ticks,
  input  logic [27:0] hold_ticks,
  input  logic [6:0]  number,
  input  logic [13:0] first_value,
  input  logic [13:0] end_value,
  input  logic [5:0]  ramp_steps,
  input  logic [2:0]  note_count,
  input  logic [27:0] notes,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] delta_bytes,
  input  logic [2:0]  delta_length,
  input  logic [7:0]  status_byte,
  input  logic [7:0]  data_one,
  input  logic [7:0]  data_two,
  input  logic [1:0]  data_count,
  input  logic [31:0] track_length,
  input  logic        last,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  event_t      expected_events[$];
  logic [31:0] track_bytes;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Appends one event with its minimal VLQ delta and advances the byte count.
  task automatic add_event(input logic [31:0] dt, input logic [7:0] st,
                           input logic [7:0] d1, input logic [7:0] d2,
                           input logic [1:0] dc);
    event_t e;
    logic [6:0] g0, g1, g2, g3;
    g0 = dt[6:0];
    g1 = dt[13:7];
    g2 = dt[20:14];
    g3 = dt[27:21];
    if (g3 != 0) begin
      e.delta_bytes = {1'b1, g3, 1'b1, g2, 1'b1, g1, 1'b0, g0};
      e.delta_length = 3'd4;
    end else if (g2 != 0) begin
      e.delta_bytes = {8'd0, 1'b1, g2, 1'b1, g1, 1'b0, g0};
      e.delta_length = 3'd3;
    end else if (g1 != 0) begin
      e.delta_bytes = {16'd0, 1'b1, g1, 1'b0, g0};
      e.delta_length = 3'd2;
    end else begin
      e.delta_bytes = {24'd0, 1'b0, g0};
      e.delta_length = 3'd1;
    end
    track_bytes = track_bytes + e.delta_length + 1 + dc;
    e.status_byte = st;
    e.data_one = d1;
    e.data_two = d2;
    e.data_count = dc;
    e.track_length = track_bytes;
    e.last = 1'b0;
    expected_events.insert(expected_events.size(), e);
  endtask

  task automatic predict_request();
    int          before_n;
    int          cnt;
    int          s;
    int          start;
    int          diff;
    int          v;
    logic [63:0] target;
    logic [31:0] elapsed;
    logic [31:0] d;
    logic [7:0]  st;
    event_t      e;
    before_n = expected_events.size();
    case (command) inside
      CMD_NOTE: begin
        cnt = (note_count == 0) ? 1 : (note_count > MaxNotes ? MaxNotes : note_count);
        for (int i = 0; i < cnt; i++)
          add_event(i == 0 ? delta_ticks : 0, ST_NOTE_ON | channel,
                    8'(notes[7*i +: 7]), 8'(first_value[7:0]), 2'd2);
        for (int i = 0; i < cnt; i++)
          add_event(i == 0 ? hold_ticks : 0, ST_NOTE_ON | channel,
                    8'(notes[7*i +: 7]), 8'd0, 2'd2);
      end
      CMD_PROG: add_event(delta_ticks, ST_PROG | channel, 8'(number), 8'd0, 2'd1);
      CMD_CTRL: add_event(delta_ticks, ST_CTRL | channel, 8'(number), first_value[7:0], 2'd2);
      CMD_PITCH: add_event(delta_ticks, ST_PITCH | channel, 8'(first_value[6:0]),
                           8'(first_value[13:7]), 2'd2);
      CMD_CRAMP, CMD_PRAMP: begin
        s = (ramp_steps > MaxSteps) ? MaxSteps : ramp_steps;
        start = first_value;
        diff = int'(end_value) - start;
        elapsed = 0;
        st = (command == CMD_PRAMP) ? (ST_PITCH | channel) : (ST_CTRL | channel);
        if (command == CMD_PRAMP)
          add_event(delta_ticks, st, 8'(first_value[6:0]), 8'(first_value[13:7]), 2'd2);
        else
          add_event(delta_ticks, st, 8'(number), first_value[7:0], 2'd2);
        for (int k = 1; k <= s; k++) begin
          // Signed division truncates toward zero, as the ramp requires.
          v = start + (k * diff) / s;
          target = (64'(hold_ticks) * k) / s;
          d = target[31:0] - elapsed;
          elapsed = elapsed + d;
          if (command == CMD_PRAMP)
            add_event(d, st, 8'(v[6:0]), 8'(v[13:7]), 2'd2);
          else
            add_event(d, st, 8'(number), v[7:0], 2'd2);
        end
      end
      CMD_END: begin
        add_event(0, ST_META, META_EOT, 8'd0, 2'd2);
        track_bytes = 0;
      end
      default: ;
    endcase
    if (expected_events.size() > before_n) begin
      e = expected_events[expected_events.size() - 1];
      e.last = 1'b1;
      expected_events[expected_events.size() - 1] = e;
    end
  endtask

  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      expected_events.delete();
      track_bytes = 0;
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event, status", status_byte, 0);
        end else begin
          want = expected_events.pop_front();
          if (delta_bytes != want.delta_bytes)
            report_mismatch("delta_bytes", delta_bytes, want.delta_bytes);
          if (delta_length != want.delta_length)
            report_mismatch("delta_length", delta_length, want.delta_length);
          if (status_byte != want.status_byte)
            report_mismatch("status_byte", status_byte, want.status_byte);
          if (data_one != want.data_one)
            report_mismatch("data_one", data_one, want.data_one);
          if (data_two != want.data_two)
            report_mismatch("data_two", data_two, want.data_two);
          if (data_count != want.data_count)
            report_mismatch("data_count", data_count, want.data_count);
          if (track_length != want.track_length)
            report_mismatch("track_length", track_length, want.track_length);
          if (last != want.last)
            report_mismatch("last", last, want.last);
        end
      end
      if (in_valid && !in_stall)
        predict_request();
    end
    pending <= expected_events.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    track_bytes = 0;
  end

endmodule

[tb/midi_track_event_encoder_top_tb.sv]
// Stimulus and verdict for the MIDI track event encoder. The checker beside
// the block does all prediction; this module only offers requests, drives the
// output stall and decides pass or fail from the checker's error count.
module midi_track_event_encoder_top_tb import mte_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = '0;
  logic [3:0]  channel = '0;
  logic [27:0] delta_ticks = '0;
  logic [27:0] hold_ticks = '0;
  logic [6:0]  number = '0;
  logic [13:0] first_value = '0;
  logic [13:0] end_value = '0;
  logic [5:0]  ramp_steps = '0;
  logic [2:0]  note_count = '0;
  logic [27:0] notes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] delta_bytes;
  logic [2:0]  delta_length;
  logic [7:0]  status_byte;
  logic [7:0]  data_one;
  logic [7:0]  data_two;
  logic [1:0]  data_count;
  logic [31:0] track_length;
  logic        last;

  int errors;
  int pending;

  // Idle percentages for the two sides, changed between phases.
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  midi_track_event_encoder_top u_top (.*);

  midi_track_event_checker u_checker (.*);

  // The receiver process. A long hold-off is counted here so the sender can
  // keep offering requests and fill the block until it stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Offers one request and returns at the edge where it is accepted. Any idle
  // gap is taken before the item is raised, so valid is written once per step
  // and an item that is waiting on stall is never changed.
  task automatic offer_request(input logic [2:0] cmd, input logic [3:0] ch,
                               input logic [27:0] dt, input logic [27:0] ht,
                               input logic [6:0] num, input logic [13:0] fv,
                               input logic [13:0] ev, input logic [5:0] st,
                               input logic [2:0] nc, input logic [27:0] nn);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 12)
      gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= cmd;
    channel <= ch;
    delta_ticks <= dt;
    hold_ticks <= ht;
    number <= num;
    first_value <= fv;
    end_value <= ev;
    ramp_steps <= st;
    note_count <= nc;
    notes <= nn;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Delta values are spread over the four VLQ lengths, boundaries included.
  function automatic logic [27:0] pick_ticks();
    case ($urandom_range(0, 5))
      0: return 28'($urandom_range(0, 127));
      1: return 28'($urandom_range(128, 16383));
      2: return 28'($urandom_range(16384, 2097151));
      3: return 28'($urandom_range(2097152, 268435455));
      4: return 28'($urandom);
      default: return 28'($urandom_range(0, 3)) << (7 * $urandom_range(0, 3));
    endcase
  endfunction

  task automatic random_request();
    int          sel;
    logic [2:0]  cmd;
    logic [5:0]  st;
    logic [2:0]  nc;
    sel = $urandom_range(0, 99);
    if (sel < 24) cmd = CMD_NOTE;
    else if (sel < 32) cmd = CMD_PROG;
    else if (sel < 42) cmd = CMD_CTRL;
    else if (sel < 52) cmd = CMD_PITCH;
    else if (sel < 70) cmd = CMD_CRAMP;
    else if (sel < 88) cmd = CMD_PRAMP;
    else if (sel < 96) cmd = CMD_END;
    else cmd = 3'd7;
    // Most ramps are short; a few run the full step range.
    st = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 8)) : 6'($urandom);
    nc = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom);
    offer_request(cmd, 4'($urandom), pick_ticks(), pick_ticks(), 7'($urandom),
                  14'($urandom), 14'($urandom), st, nc, 28'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: every command, the VLQ length boundaries, note count
    // clamping at both ends, zero, one and full ramps in both directions, the
    // ignored command and end of track with its count clear.
    sender_idle_pct = 26;
    receiver_idle_pct = 62;
    offer_request(CMD_END, 4'd0, 28'd0, 28'd0, 7'd0, 14'd0, 14'd0, 6'd0, 3'd1, 28'd0);
    offer_request(CMD_NOTE, 4'd15, 28'd127, 28'd128, 7'd0, 14'h3FFF, 14'd0, 6'd0, 3'd0,
                  28'hFFFFFFF);
    offer_request(CMD_NOTE, 4'd3, 28'd16383, 28'd16384, 7'd0, 14'd100, 14'd0, 6'd0, 3'd4,
                  {7'd127, 7'd64, 7'd1, 7'd0});
    offer_request(CMD_NOTE, 4'd1, 28'd2097151, 28'd2097152, 7'd0, 14'd1, 14'd0, 6'd0, 3'd5,
                  28'h1234567);
    offer_request(CMD_NOTE, 4'd2, 28'hFFFFFFF, 28'd0, 7'd0, 14'd255, 14'd0, 6'd0, 3'd7,
                  28'h7654321);
    offer_request(CMD_PROG, 4'd0, 28'd0, 28'd0, 7'd127, 14'h3FFF, 14'h3FFF, 6'd63, 3'd1,
                  28'd0);
    offer_request(CMD_PROG, 4'd15, 28'hFFFFFFF, 28'hFFFFFFF, 7'd0, 14'd0, 14'd0, 6'd0, 3'd1,
                  28'd0);
    offer_request(CMD_CTRL, 4'd7, 28'd1, 28'd0, 7'd64, 14'h3FFF, 14'd0, 6'd0, 3'd1, 28'd0);
    offer_request(CMD_CTRL, 4'd8, 28'd128, 28'd0, 7'd0, 14'd0, 14'd0, 6'd0, 3'd1, 28'd0);
    offer_request(CMD_PITCH, 4'd9, 28'd0, 28'd0, 7'd0, 14'h3FFF, 14'd0, 6'd0, 3'd1, 28'd0);
    offer_request(CMD_PITCH, 4'd4, 28'd5, 28'd0, 7'd0, 14'h2000, 14'd0, 6'd0, 3'd1, 28'd0);
    offer_request(CMD_CRAMP, 4'd5, 28'd10, 28'd100, 7'd7, 14'd0, 14'd127, 6'd0, 3'd1, 28'd0);
    offer_request(CMD_CRAMP, 4'd5, 28'd10, 28'd100, 7'd7, 14'd0, 14'd127, 6'd1, 3'd1, 28'd0);
    offer_request(CMD_CRAMP, 4'd6, 28'd0, 28'd10, 7'd1, 14'd100, 14'd3, 6'd7, 3'd1, 28'd0);
    offer_request(CMD_PRAMP, 4'd11, 28'd0, 28'hFFFFFFF, 7'd0, 14'h3FFF, 14'd0, 6'd63, 3'd1,
                  28'd0);
    offer_request(CMD_PRAMP, 4'd12, 28'd300, 28'd7, 7'd0, 14'd0, 14'h3FFF, 6'd63, 3'd1,
                  28'd0);
    offer_request(CMD_PRAMP, 4'd13, 28'd1, 28'd0, 7'd0, 14'd8192, 14'd8191, 6'd3, 3'd1,
                  28'd0);
    offer_request(3'd7, 4'd0, 28'hFFFFFFF, 28'hFFFFFFF, 7'd127, 14'h3FFF, 14'h3FFF, 6'd63,
                  3'd7, 28'hFFFFFFF);
    offer_request(CMD_END, 4'd15, 28'hFFFFFFF, 28'd0, 7'd0, 14'd0, 14'd0, 6'd0, 3'd1, 28'd0);
    offer_request(CMD_CTRL, 4'd0, 28'd0, 28'd0, 7'd0, 14'd0, 14'd0, 6'd0, 3'd1, 28'd0);

    // The sender pauses here until every expected event has come out.
    wait_drained();

    // Random phase one: sender idles lightly, receiver heavily.
    repeat (60) random_request();

    // The receiver holds off for a long stretch while requests keep coming,
    // so the request queue fills and the block stalls its input.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    long_hold_req = 1'b1;
    repeat (12) random_request();
    wait_drained();

    // Random phase two: the idling rates swap.
    sender_idle_pct = 62;
    receiver_idle_pct = 26;
    repeat (44) random_request();

    // Random phase three: both sides run flat out.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (44) random_request();

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("midi_track_event_encoder_top_tb: clean");
    else
      $display("midi_track_event_encoder_top_tb: errors");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("midi_track_event_encoder_top_tb: errors");
    $finish;
  end

endmodule
